[sv/two_button_chord_detector_assert.svh]
// Assertion macros shared by the chord detector RTL.
`ifndef TWO_BUTTON_CHORD_DETECTOR_ASSERT_SVH
`define TWO_BUTTON_CHORD_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TBCD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define TBCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/tbcd_pkg.sv]
// Types and constants for the two-button chord detector.
package tbcd_pkg;

	localparam int unsigned TimeW   = 32;
	localparam int unsigned CfgW    = 16;
	localparam int unsigned CfgIdxW = 8;
	localparam int unsigned InDataW = 40;
	localparam int unsigned OutDataW = 8;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_ARMED   = 2'd1,
		PH_LATCHED = 2'd2,
		PH_LOCKOUT = 2'd3
	} phase_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_HOLD_TIME    = 8'd0,
		REG_LOCKOUT_TIME = 8'd1,
		REG_PAIR_TIME    = 8'd2,
		REG_STALE_TIME   = 8'd3
	} reg_idx_t;

	localparam logic [CfgW-1:0] HoldTimeRst    = 16'd500;
	localparam logic [CfgW-1:0] LockoutTimeRst = 16'd200;
	localparam logic [CfgW-1:0] PairTimeRst    = 16'd80;
	localparam logic [CfgW-1:0] StaleTimeRst   = 16'd1000;

	typedef struct packed {
		logic [CfgW-1:0] hold_time;
		logic [CfgW-1:0] release_lockout_time;
		logic [CfgW-1:0] pair_window_time;
		logic [CfgW-1:0] stale_turn_time;
	} cfg_t;

	typedef struct packed {
		phase_t           chord_phase;
		logic [TimeW-1:0] phase_since;
		logic             held_prev;
		logic             held_next;
		logic [TimeW-1:0] held_since;
	} state_t;

	typedef struct packed {
		logic             func;
		logic             left_down;
		logic             right_down;
		logic [TimeW-1:0] now_time;
		logic             turn_prev;
		logic             turn_next;
		logic             from_chord_button;
	} item_t;

	typedef struct packed {
		logic emit_next;
		logic emit_prev;
		logic fired;
		logic holds_input;
	} result_t;

endpackage

[sv/tbcd_step.sv]
// Next-state and result logic for one word of the chord detector.
module tbcd_step (
	input  tbcd_pkg::state_t  state,
	input  tbcd_pkg::cfg_t    cfg,
	input  tbcd_pkg::item_t   item,
	output tbcd_pkg::state_t  state_nxt,
	output tbcd_pkg::result_t res
);
	import tbcd_pkg::*;

	logic [TimeW-1:0] phase_age;
	logic [TimeW-1:0] held_age;
	logic             both;
	logic             either;
	logic             released;

	assign phase_age = item.now_time - state.phase_since;
	assign held_age  = item.now_time - state.held_since;
	assign both      = item.left_down & item.right_down;
	assign either    = item.left_down | item.right_down;

	always_comb begin
		state_nxt = state;
		res       = '0;
		released  = 1'b0;
		if (!item.func) begin
			case (state.chord_phase)
				PH_IDLE: begin
					if (both) begin
						state_nxt.chord_phase = PH_ARMED;
						state_nxt.phase_since = item.now_time;
						res.holds_input       = 1'b1;
					end
				end
				PH_ARMED: begin
					if (!both) begin
						state_nxt.chord_phase = PH_IDLE;
					end else begin
						res.holds_input = 1'b1;
						if (phase_age >= {{(TimeW-CfgW){1'b0}}, cfg.hold_time}) begin
							res.fired             = 1'b1;
							state_nxt.held_prev   = 1'b0;
							state_nxt.held_next   = 1'b0;
							state_nxt.chord_phase = PH_LATCHED;
							state_nxt.phase_since = item.now_time;
						end
					end
				end
				PH_LATCHED: begin
					res.holds_input = 1'b1;
					if (!either) begin
						state_nxt.chord_phase = PH_LOCKOUT;
						state_nxt.phase_since = item.now_time;
					end
				end
				PH_LOCKOUT: begin
					if (either) begin
						state_nxt.phase_since = item.now_time;
					end else if (phase_age >=
							{{(TimeW-CfgW){1'b0}}, cfg.release_lockout_time}) begin
						state_nxt.chord_phase = PH_IDLE;
					end
				end
				default: begin
					state_nxt.chord_phase = PH_IDLE;
				end
			endcase
		end else begin
			// Age out or release a pending turn first; a stale drop wins.
			if (state.held_prev || state.held_next) begin
				if (held_age >= {{(TimeW-CfgW){1'b0}}, cfg.stale_turn_time}) begin
					state_nxt.held_prev = 1'b0;
					state_nxt.held_next = 1'b0;
				end else if (held_age >= {{(TimeW-CfgW){1'b0}}, cfg.pair_window_time}) begin
					res.emit_prev       = state.held_prev;
					res.emit_next       = state.held_next;
					state_nxt.held_prev = 1'b0;
					state_nxt.held_next = 1'b0;
					released            = 1'b1;
				end
			end
			if (!released && (item.turn_prev || item.turn_next)) begin
				if (!item.from_chord_button) begin
					res.emit_prev = item.turn_prev;
					res.emit_next = item.turn_next;
				end else if (state.chord_phase != PH_ARMED &&
						state.chord_phase != PH_LATCHED) begin
					state_nxt.held_prev  = item.turn_prev;
					state_nxt.held_next  = item.turn_next;
					state_nxt.held_since = item.now_time;
				end
			end
		end
	end

endmodule

[sv/two_button_chord_detector.sv]
// Two-button chord detector with page-turn filter: top level.
// A word accepted on the input is registered in stage 1, then processed
// and moved into the result register, which drives the master side.
// Throughput: one word per cycle unless the sink holds off; the input and
// result registers form a two-stage pipe; the update is subtract and compare.
// Reset (arst_n low, asynchronous): phase idle, timestamps zero, no held turn,
// registers back to 500 / 200 / 80 / 1000 ms, both stages empty.
module two_button_chord_detector (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tbcd_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [tbcd_pkg::CfgW-1:0]         cfg_data,
	// input word stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata, low bit up: left_down, right_down, now_time[31:0], turn_prev,
	// turn_next, from_chord_button, three zero bits
	input  logic [tbcd_pkg::InDataW-1:0]      s_axis_tdata,
	// tuser: func (0 button sample, 1 page-turn request)
	input  logic                              s_axis_tuser,
	// result word stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tdata, low bit up: holds_input, fired, emit_prev, emit_next, four zero bits
	output logic [tbcd_pkg::OutDataW-1:0]     m_axis_tdata
);
	import tbcd_pkg::*;

	`include "two_button_chord_detector_assert.svh"

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s1;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	// Configuration is always taken; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_time            <= HoldTimeRst;
			cfg_q.release_lockout_time <= LockoutTimeRst;
			cfg_q.pair_window_time     <= PairTimeRst;
			cfg_q.stale_turn_time      <= StaleTimeRst;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HOLD_TIME:    cfg_q.hold_time            <= cfg_data;
				REG_LOCKOUT_TIME: cfg_q.release_lockout_time <= cfg_data;
				REG_PAIR_TIME:    cfg_q.pair_window_time     <= cfg_data;
				REG_STALE_TIME:   cfg_q.stale_turn_time      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Stage 1 moves into the result register when that register is free or
	// being drained this cycle; the input side refills behind it.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Unpack the incoming word; payload needs no reset.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.func              <= s_axis_tuser;
			item_s1.left_down         <= s_axis_tdata[0];
			item_s1.right_down        <= s_axis_tdata[1];
			item_s1.now_time          <= s_axis_tdata[33:2];
			item_s1.turn_prev         <= s_axis_tdata[34];
			item_s1.turn_next         <= s_axis_tdata[35];
			item_s1.from_chord_button <= s_axis_tdata[36];
		end
	end

	tbcd_step u_step (
		.state     (state_q),
		.cfg       (cfg_q),
		.item      (item_s1),
		.state_nxt (state_nxt),
		.res       (res_s1)
	);

	// Chord and held-turn state: advance once per word as it leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.chord_phase <= PH_IDLE;
			state_q.phase_since <= '0;
			state_q.held_prev   <= 1'b0;
			state_q.held_next   <= 1'b0;
			state_q.held_since  <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register: hold the word until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(OutDataW-4){1'b0}}, res_s2};

	// A fired chord always swallows the sample that fired it.
	`TBCD_ASSERT_NOW(a_fire_swallows, clk, arst_n, valid_s2 && res_s2.fired, res_s2.holds_input, "fired without holds_input")
	// Button and turn results never mix in one word.
	`TBCD_ASSERT_NOW(a_no_mixed_result, clk, arst_n, valid_s2 && (res_s2.holds_input || res_s2.fired), !res_s2.emit_prev && !res_s2.emit_next, "button and turn flags in one result")
	// Firing latches the chord and clears any pending turn.
	`TBCD_ASSERT_NEXT(a_fire_latches, clk, arst_n, advance && res_s1.fired, state_q.chord_phase == PH_LATCHED && !state_q.held_prev && !state_q.held_next, "fire did not latch and clear")
	// Back-pressure on the input only while both stages are occupied.
	`TBCD_ASSERT_NOW(a_stall_needs_word, clk, arst_n, !s_axis_tready, valid_s1 && valid_s2, "input stalled with a free stage")

endmodule

[verif/tb_two_button_chord_detector.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the two-button chord detector and its page-turn filter.
module tb_two_button_chord_detector;
	import tbcd_pkg::*;

	// Clock, handshake pacing and run limits.
	localparam int HalfPeriod    = 4;
	localparam int ResetCycles   = 4;
	localparam int SettleCycles  = 4;     // margin for the block to go quiet
	localparam int StallLimit    = 3000;  // cycles with no word moving anywhere
	localparam int PhaseCount    = 6;
	localparam int WordsPerPhase = 190;

	// One word waiting in the backlog; park_all asks the sender to hold it
	// back until every result already owed has come out.
	typedef struct {
		item_t w;
		bit    park_all;
	} backlog_word_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgW-1:0]     cfg_data;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	// low bit up: left_down, right_down, now_time[31:0], turn_prev, turn_next,
	// from_chord_button, three zero bits
	logic [InDataW-1:0]  s_axis_tdata;
	// func: 0 button sample, 1 page-turn request
	logic                s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	// low bit up: holds_input, fired, emit_prev, emit_next, four zero bits
	logic [OutDataW-1:0] m_axis_tdata;

	two_button_chord_detector dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Predictor state: its own copy of the timing registers, the chord phase
	// and the parked page turn.
	cfg_t             timing;
	phase_t           chord_ph;
	logic [TimeW-1:0] ph_stamp;
	logic             park_prev;
	logic             park_next;
	logic [TimeW-1:0] park_stamp;

	backlog_word_t word_backlog[$];
	result_t       due_results[$];

	int unsigned src_idle_pct;
	int unsigned sink_idle_pct;
	int unsigned n_queued;
	int unsigned n_taken;
	int unsigned n_results;
	int unsigned n_fired;
	int unsigned n_emitted;
	int unsigned n_reg_writes;
	int unsigned n_bad;
	int unsigned stall_cycles;
	bit          word_taken;
	logic [TimeW-1:0] ms_now;

	initial begin
		clk = 1'b0;
	end

	always begin
		#HalfPeriod clk = ~clk;
	end

	// Advance the predicted chord and turn-filter state by one word and
	// work out the result it owes.
	task automatic chord_predict(input item_t w, output result_t r);
		logic             both;
		logic             either;
		logic             go_on;
		logic [TimeW-1:0] age;
		begin
			r = '0;
			if (!w.func) begin
				both   = w.left_down & w.right_down;
				either = w.left_down | w.right_down;
				age    = w.now_time - ph_stamp;
				case (chord_ph)
					PH_IDLE: begin
						if (both) begin
							chord_ph      = PH_ARMED;
							ph_stamp      = w.now_time;
							r.holds_input = 1'b1;
						end
					end
					PH_ARMED: begin
						if (!both) begin
							chord_ph = PH_IDLE;
						end else begin
							r.holds_input = 1'b1;
							// firing throws away any parked turn
							if (age >= {16'd0, timing.hold_time}) begin
								r.fired   = 1'b1;
								park_prev = 1'b0;
								park_next = 1'b0;
								chord_ph  = PH_LATCHED;
								ph_stamp  = w.now_time;
							end
						end
					end
					PH_LATCHED: begin
						r.holds_input = 1'b1;
						if (!either) begin
							chord_ph = PH_LOCKOUT;
							ph_stamp = w.now_time;
						end
					end
					default: begin
						// any press restarts the quiet period
						if (either) begin
							ph_stamp = w.now_time;
						end else if (age >= {16'd0, timing.release_lockout_time}) begin
							chord_ph = PH_IDLE;
						end
					end
				endcase
			end else begin
				go_on = 1'b1;
				if (park_prev | park_next) begin
					age = w.now_time - park_stamp;
					// stale wins over the pair window; after a stale drop the
					// request is still handled, after a release it is not
					if (age >= {16'd0, timing.stale_turn_time}) begin
						park_prev = 1'b0;
						park_next = 1'b0;
					end else if (age >= {16'd0, timing.pair_window_time}) begin
						r.emit_prev = park_prev;
						r.emit_next = park_next;
						park_prev   = 1'b0;
						park_next   = 1'b0;
						go_on       = 1'b0;
					end
				end
				if (go_on && (w.turn_prev | w.turn_next)) begin
					if (!w.from_chord_button) begin
						r.emit_prev = w.turn_prev;
						r.emit_next = w.turn_next;
					end else if (chord_ph != PH_ARMED && chord_ph != PH_LATCHED) begin
						park_prev  = w.turn_prev;
						park_next  = w.turn_next;
						park_stamp = w.now_time;
					end
				end
			end
		end
	endtask

	task automatic check_field(input string fname, input logic want, input logic got);
		if (want !== got) begin
			n_bad++;
			$display("%0t ns: %s mismatch, expected %0b, actual %0b", $time, fname, want, got);
		end
	endtask

	// Sample both sides at the rising edge: update the registers copy on a
	// config write, check the oldest owed result, then predict the new word.
	always @(posedge clk) begin : scoreboard
		item_t   seen;
		result_t want;
		result_t owed;
		bit      moved;
		if (!arst_n) begin
			timing     = '{HoldTimeRst, LockoutTimeRst, PairTimeRst, StaleTimeRst};
			chord_ph   = PH_IDLE;
			ph_stamp   = '0;
			park_prev  = 1'b0;
			park_next  = 1'b0;
			park_stamp = '0;
			word_taken = 1'b0;
		end else begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				n_reg_writes++;
				case (cfg_index)
					REG_HOLD_TIME:    timing.hold_time            = cfg_data;
					REG_LOCKOUT_TIME: timing.release_lockout_time = cfg_data;
					REG_PAIR_TIME:    timing.pair_window_time     = cfg_data;
					REG_STALE_TIME:   timing.stale_turn_time      = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				moved = 1'b1;
				n_results++;
				if (m_axis_tdata[1]) n_fired++;
				if (m_axis_tdata[2] | m_axis_tdata[3]) n_emitted++;
				if (due_results.size() == 0) begin
					n_bad++;
					$display("%0t ns: result %0h with nothing owed", $time, m_axis_tdata);
				end else begin
					want = due_results.pop_front();
					check_field("holds_input", want.holds_input, m_axis_tdata[0]);
					check_field("fired", want.fired, m_axis_tdata[1]);
					check_field("emit_prev", want.emit_prev, m_axis_tdata[2]);
					check_field("emit_next", want.emit_next, m_axis_tdata[3]);
				end
			end
			word_taken = s_axis_tvalid && s_axis_tready;
			if (word_taken) begin
				moved                  = 1'b1;
				seen.func              = s_axis_tuser;
				seen.left_down         = s_axis_tdata[0];
				seen.right_down        = s_axis_tdata[1];
				seen.now_time          = s_axis_tdata[33:2];
				seen.turn_prev         = s_axis_tdata[34];
				seen.turn_next         = s_axis_tdata[35];
				seen.from_chord_button = s_axis_tdata[36];
				chord_predict(seen, owed);
				due_results.push_back(owed);
				n_taken++;
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
		end
	end

	// Drive both streams at the falling edge. Hold a word until it is taken,
	// then either present the next one or drop tvalid for an idle cycle.
	always @(negedge clk) begin : driver
		backlog_word_t nw;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
			if (!s_axis_tvalid || word_taken) begin
				if (word_backlog.size() != 0
						&& !(word_backlog[0].park_all && due_results.size() != 0)
						&& $urandom_range(99) >= src_idle_pct) begin
					nw = word_backlog.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser  <= nw.w.func;
					s_axis_tdata  <= {3'b000, nw.w.from_chord_button, nw.w.turn_next,
						nw.w.turn_prev, nw.w.now_time, nw.w.right_down, nw.w.left_down};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	initial begin : watchdog
		stall_cycles = 0;
		@(posedge arst_n);
		while (stall_cycles < StallLimit) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	task automatic push_word(input logic func, input logic l, input logic r,
			input logic [TimeW-1:0] t, input logic tp, input logic tn, input logic fc);
		backlog_word_t bw;
		bw.w.func              = func;
		bw.w.left_down         = l;
		bw.w.right_down        = r;
		bw.w.now_time          = t;
		bw.w.turn_prev         = tp;
		bw.w.turn_next         = tn;
		bw.w.from_chord_button = fc;
		// now and then, hold the sender off until the pipe has drained
		bw.park_all = ($urandom_range(99) == 0) || (n_queued % 200 == 100);
		word_backlog.push_back(bw);
		n_queued++;
	endtask

	// Button sample at the running clock; turn fields carry noise.
	task automatic push_sample(input logic l, input logic r);
		push_word(1'b0, l, r, ms_now, 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)));
	endtask

	// Turn request at the running clock; button fields carry noise.
	task automatic push_turn(input logic tp, input logic tn, input logic fc);
		push_word(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)), ms_now, tp, tn, fc);
	endtask

	// Time step that lands close to a threshold more often than anything else, with
	// tiny or zero steps, broad steps and wild jumps across the wrap.
	function automatic logic [TimeW-1:0] gap_near(input logic [CfgW-1:0] thr);
		case ($urandom_range(9))
			0, 1:       return $urandom_range(3);
			2, 3, 4, 5: return (thr >= 2) ? thr + $urandom_range(4) - 2 : thr + $urandom_range(2);
			6, 7:       return $urandom_range({16'd0, thr} * 2 + 1);
			8:          return $urandom();
			default:    return '0;
		endcase
	endfunction

	// Let the last results out and give the block time to go quiet.
	task automatic wait_quiet();
		while (n_taken != n_queued || due_results.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Present one register write and hold it until the block takes it.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Full chord: press both, hold around the hold time with the odd turn
	// request or slip, release, then sit out the lockout.
	task automatic chord_run();
		logic l;
		ms_now = ms_now + gap_near(timing.release_lockout_time);
		push_sample(1'b1, 1'b1);
		repeat ($urandom_range(1, 5)) begin
			ms_now = ms_now + gap_near(timing.hold_time);
			case ($urandom_range(7))
				0:       push_turn(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
				1:       push_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
				default: push_sample(1'b1, 1'b1);
			endcase
		end
		if ($urandom_range(2) != 0) begin
			l = 1'($urandom_range(1));
			ms_now = ms_now + gap_near(timing.pair_window_time);
			push_sample(l, !l);
		end
		ms_now = ms_now + $urandom_range(20);
		push_sample(1'b0, 1'b0);
		repeat ($urandom_range(0, 3)) begin
			ms_now = ms_now + gap_near(timing.release_lockout_time);
			if ($urandom_range(4) == 0) begin
				push_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
			end else begin
				push_sample(1'b0, 1'b0);
			end
		end
	endtask

	// Turn requests spaced around the pair window and the stale age.
	task automatic turn_run();
		push_turn(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(3) != 0);
		repeat ($urandom_range(1, 3)) begin
			if ($urandom_range(1) == 0) begin
				ms_now = ms_now + gap_near(timing.pair_window_time);
			end else begin
				ms_now = ms_now + gap_near(timing.stale_turn_time);
			end
			push_turn(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(3) != 0);
		end
	endtask

	initial begin : stimulus
		int unsigned phase_start;
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		m_axis_tready <= 1'b0;
		src_idle_pct  = 13;
		sink_idle_pct = 83;
		n_queued      = 0;
		n_taken       = 0;
		n_results     = 0;
		n_fired       = 0;
		n_emitted     = 0;
		n_reg_writes  = 0;
		n_bad         = 0;
		ms_now        = '0;
		repeat (ResetCycles) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part, reset timing: hold 500, lockout 200, pair 80, stale 1000.
		push_word(1'b0, 1'b0, 1'b0, 32'd0,    1'b0, 1'b0, 1'b0); // idle, nothing pressed
		push_word(1'b0, 1'b1, 1'b1, 32'd10,   1'b1, 1'b1, 1'b1); // arm, turn bits ignored
		push_word(1'b0, 1'b1, 1'b1, 32'd509,  1'b0, 1'b0, 1'b0); // one short of the hold
		push_word(1'b1, 1'b0, 1'b0, 32'd520,  1'b1, 1'b0, 1'b1); // chord turn swallowed
		push_word(1'b0, 1'b1, 1'b1, 32'd510,  1'b0, 1'b0, 1'b0); // exactly the hold: fire
		push_word(1'b0, 1'b1, 1'b0, 32'd600,  1'b0, 1'b0, 1'b0); // latched, one still down
		push_word(1'b1, 1'b1, 1'b1, 32'd610,  1'b0, 1'b1, 1'b0); // other button passes
		push_word(1'b0, 1'b0, 1'b0, 32'd700,  1'b0, 1'b0, 1'b0); // release into lockout
		push_word(1'b0, 1'b0, 1'b1, 32'd750,  1'b0, 1'b0, 1'b0); // press restarts lockout
		push_word(1'b0, 1'b0, 1'b0, 32'd949,  1'b0, 1'b0, 1'b0); // one short of lockout
		push_word(1'b0, 1'b0, 1'b0, 32'd950,  1'b0, 1'b0, 1'b0); // back to idle
		push_word(1'b1, 1'b0, 1'b0, 32'd1000, 1'b1, 1'b1, 1'b1); // park both directions
		push_word(1'b1, 1'b0, 1'b0, 32'd1079, 1'b0, 1'b0, 1'b0); // one short of the window
		push_word(1'b1, 1'b0, 1'b0, 32'd1080, 1'b0, 1'b0, 1'b0); // release the pair
		push_word(1'b1, 1'b0, 1'b0, 32'd2000, 1'b0, 1'b1, 1'b1); // park next
		push_word(1'b1, 1'b0, 1'b0, 32'd2010, 1'b1, 1'b0, 1'b1); // newer turn replaces it
		push_word(1'b1, 1'b0, 1'b0, 32'd3010, 1'b0, 1'b1, 1'b0); // stale drop, then pass
		push_word(1'b1, 1'b0, 1'b0, 32'hFFFF_FFF0, 1'b1, 1'b0, 1'b1); // park across wrap
		push_word(1'b1, 1'b0, 1'b0, 32'h0000_0040, 1'b0, 1'b1, 1'b0); // release, drop new
		push_word(1'b1, 1'b0, 1'b0, 32'h0000_0050, 1'b0, 1'b0, 1'b1); // empty request
		push_word(1'b0, 1'b1, 1'b1, 32'hFFFF_FF00, 1'b0, 1'b0, 1'b0); // arm before wrap
		push_word(1'b1, 1'b0, 1'b0, 32'hFFFF_FF10, 1'b0, 1'b1, 1'b1); // armed: swallow
		push_word(1'b0, 1'b1, 1'b1, 32'h0000_01F4, 1'b0, 1'b0, 1'b0); // fire across wrap
		push_word(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0); // lockout, top time
		push_word(1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0); // press in lockout
		ms_now = 32'h0001_0000;

		for (int k = 0; k < PhaseCount; k++) begin
			wait_quiet();
			case (k)
				0: ;
				1: begin
					write_reg(REG_HOLD_TIME, '0);
					write_reg(REG_LOCKOUT_TIME, '0);
					write_reg(REG_PAIR_TIME, '0);
					write_reg(REG_STALE_TIME, '0);
				end
				2: begin
					write_reg(REG_HOLD_TIME, '1);
					write_reg(REG_LOCKOUT_TIME, '1);
					write_reg(REG_PAIR_TIME, '1);
					write_reg(REG_STALE_TIME, '1);
				end
				3: begin
					write_reg(REG_HOLD_TIME, 16'($urandom_range(1, 60)));
					write_reg(REG_LOCKOUT_TIME, 16'($urandom_range(1, 60)));
					write_reg(REG_PAIR_TIME, 16'($urandom_range(1, 60)));
					write_reg(REG_STALE_TIME, 16'($urandom_range(1, 60)));
				end
				4: begin
					write_reg(REG_HOLD_TIME, 16'($urandom()));
					write_reg(REG_LOCKOUT_TIME, 16'($urandom()));
					write_reg(REG_PAIR_TIME, 16'($urandom()));
					write_reg(REG_STALE_TIME, 16'($urandom()));
				end
				default: begin
					// pair window longer than the stale age: stale always wins
					write_reg(REG_HOLD_TIME, '0);
					write_reg(REG_LOCKOUT_TIME, '1);
					write_reg(REG_PAIR_TIME, '1);
					write_reg(REG_STALE_TIME, 16'($urandom_range(1, 300)));
				end
			endcase
			// an index past the last register must leave the timing alone
			write_reg(8'($urandom_range(255, REG_STALE_TIME + 1)), 16'($urandom()));
			@(negedge clk);
			cfg_valid <= 1'b0;

			if (k < 2) begin
				src_idle_pct  = 13;
				sink_idle_pct = 83;
			end else if (k < 4) begin
				src_idle_pct  = 83;
				sink_idle_pct = 13;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end

			// Mostly well-formed chords and turn sequences, some raw noise.
			phase_start = n_queued;
			while (n_queued - phase_start < WordsPerPhase) begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4: chord_run();
					5, 6, 7:       turn_run();
					default: begin
						repeat ($urandom_range(1, 4)) begin
							push_word(1'($urandom_range(1)), 1'($urandom_range(1)),
								1'($urandom_range(1)), $urandom(), 1'($urandom_range(1)),
								1'($urandom_range(1)), 1'($urandom_range(1)));
						end
					end
				endcase
			end
		end

		wait_quiet();
		$display("Ran %0d words through %0d timing settings with %0d register writes.",
			n_taken, PhaseCount, n_reg_writes);
		$display("Checked %0d results: %0d chord fires, %0d page turns delivered.",
			n_results, n_fired, n_emitted);
		if (n_bad == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
